### sv/ffpa_pkg.sv
// Package for the first-fit page allocator: sizes, entry codes, opcodes,
// status codes, controller states and the result record.
// No dependencies.
`timescale 1ns / 1ps

package ffpa_pkg;

	localparam int PAGES = 1024;
	localparam int IDX_W = $clog2(PAGES);
	localparam int FC_W  = $clog2(PAGES + 1);
	localparam int PG_W  = 20;
	localparam int CNT_W = 11;
	localparam int ENT_W = 12;

	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(PAGES - 1);
	localparam logic [ENT_W-1:0] ENT_FREE  = '0;
	localparam logic [ENT_W-1:0] CONT_MARK = '1;
	localparam logic [CNT_W-1:0] CNT_MAX   = '1;

	typedef enum logic [1:0] {
		OP_ALLOC    = 2'd0,
		OP_FREE_CNT = 2'd1,
		OP_FREE_RUN = 2'd2,
		OP_RSVD     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NO_ROOM   = 2'd1,
		STAT_OUTSIDE   = 2'd2,
		STAT_BAD_COUNT = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_MARK,
		ST_FREE
	} fsm_t;

	typedef struct packed {
		logic             valid;
		status_t          status;
		logic [PG_W-1:0]  granted;
		logic [CNT_W-1:0] freed;
		logic [CNT_W-1:0] free_pages;
	} result_t;

	function automatic logic [CNT_W-1:0] sat_cnt(input logic [FC_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'(CNT_MAX)) ? CNT_MAX : w[CNT_W-1:0];
	endfunction

endpackage

### sv/first_fit_page_allocator_core.sv
// Top level of the first-fit page allocator: region base register, page map
// RAM and sequencer. Uses ffpa_pkg, ffpa_page_ram and ffpa_ctrl.
//
// Channel   Signals                                 Transaction when
// request   start, busy, op, page_number,           start and not busy
//           page_count
// result    done, status, granted_page,             done (one cycle, no stall)
//           pages_freed, free_pages
// config    cfg_valid, cfg_ready, cfg_data          cfg_valid and cfg_ready
//
// After reset a clearing pass writes all PAGES map entries, one per cycle, and
// busy stays high until it ends. Rejected requests answer in the next cycle.
// An allocate scans the map one entry per cycle through the RAM read port,
// then writes one map entry per granted page. A free streams read and
// write-back one entry per cycle. The result receiver cannot stall; a new
// request may be taken in the cycle that a result is shown.
`timescale 1ns / 1ps

module first_fit_page_allocator_core import ffpa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       op,
	input  logic [PG_W-1:0]  page_number,
	input  logic [CNT_W-1:0] page_count,
	output logic             done,
	output logic [1:0]       status,
	output logic [PG_W-1:0]  granted_page,
	output logic [CNT_W-1:0] pages_freed,
	output logic [CNT_W-1:0] free_pages,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [PG_W-1:0]  cfg_data
);

	logic [PG_W-1:0]  base_q;
	result_t          res;
	logic             mem_we, mem_rd_en;
	logic [IDX_W-1:0] mem_wr_addr, mem_rd_addr;
	logic [ENT_W-1:0] mem_wr_data, mem_rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= cfg_data;
		end
	end

	ffpa_page_ram #(
		.WIDTH (ENT_W),
		.DEPTH (PAGES),
		.AW    (IDX_W)
	) u_ram (
		.clk     (clk),
		.we      (mem_we),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	ffpa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.op          (op),
		.page_number (page_number),
		.page_count  (page_count),
		.base        (base_q),
		.busy        (busy),
		.res         (res),
		.mem_we      (mem_we),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	assign done         = res.valid;
	assign status       = res.status;
	assign granted_page = res.granted;
	assign pages_freed  = res.freed;
	assign free_pages   = res.free_pages;

endmodule

### sv/ffpa_page_ram.sv
// Generic single-port-write, single-port-read synchronous RAM that holds
// the page map. Read data is registered. No dependencies.
`timescale 1ns / 1ps

module ffpa_page_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### sv/ffpa_ctrl.sv
// Sequencer of the page allocator: clearing pass, first-fit scan, run
// marking and release streaming over the page map RAM. Uses ffpa_pkg.
`timescale 1ns / 1ps

module ffpa_ctrl import ffpa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       op,
	input  logic [PG_W-1:0]  page_number,
	input  logic [CNT_W-1:0] page_count,
	input  logic [PG_W-1:0]  base,
	output logic             busy,
	output result_t          res,
	output logic             mem_we,
	output logic [IDX_W-1:0] mem_wr_addr,
	output logic [ENT_W-1:0] mem_wr_data,
	output logic             mem_rd_en,
	output logic [IDX_W-1:0] mem_rd_addr,
	input  logic [ENT_W-1:0] mem_rd_data
);

	fsm_t             state_q, state_nx;
	logic [IDX_W-1:0] rd_addr_q, addr_s1, wr_ptr_q, end_q, start_q, clr_q;
	logic             issue_q, vld_s1, stored_q, first_q;
	logic [CNT_W-1:0] count_q, left_q;
	logic [FC_W-1:0]  run_q, freed_q, free_cnt_q;
	result_t          res_q;

	logic             acc, go_alloc, go_free;
	status_t          imm_stat;
	logic [PG_W-1:0]  rel;
	logic [FC_W-1:0]  run_nx, freed_nx;
	logic [IDX_W-1:0] start_nx;
	logic             hit, scan_fail, mark_last;
	logic             is_cont, stop_nowrite, rel_do, fin_free;
	logic [CNT_W-1:0] left_eff;

	assign acc = start && (state_q == ST_IDLE);
	assign rel = page_number - base;

	always_comb begin
		imm_stat = STAT_OK;
		go_alloc = 1'b0;
		go_free  = 1'b0;
		case (op_t'(op))
			OP_ALLOC: begin
				if (page_count == '0) begin
					imm_stat = STAT_BAD_COUNT;
				end else if (32'(free_cnt_q) < 32'(page_count)) begin
					imm_stat = STAT_NO_ROOM;
				end else begin
					go_alloc = 1'b1;
				end
			end
			OP_FREE_CNT, OP_FREE_RUN: begin
				if ((op_t'(op) == OP_FREE_CNT) && (page_count == '0)) begin
					imm_stat = STAT_BAD_COUNT;
				end else if (rel >= PG_W'(PAGES)) begin
					imm_stat = STAT_OUTSIDE;
				end else begin
					go_free = 1'b1;
				end
			end
			default: begin
				imm_stat = STAT_BAD_COUNT;
			end
		endcase
	end

	always_comb begin
		run_nx    = (mem_rd_data == ENT_FREE) ? run_q + FC_W'(1) : '0;
		hit       = (state_q == ST_SCAN) && vld_s1 && (run_nx == FC_W'(count_q));
		scan_fail = (state_q == ST_SCAN) && vld_s1 && !hit && (addr_s1 == LAST_IDX);
		start_nx  = IDX_W'(({1'b0, addr_s1} + (IDX_W + 1)'(1)) - (IDX_W + 1)'(count_q));
		mark_last = (wr_ptr_q == end_q);

		is_cont      = (mem_rd_data == CONT_MARK);
		stop_nowrite = vld_s1 && stored_q &&
			(first_q ? ((mem_rd_data == ENT_FREE) || is_cont) : !is_cont);
		rel_do       = (state_q == ST_FREE) && vld_s1 && !stop_nowrite;
		left_eff     = (stored_q && first_q) ? mem_rd_data[CNT_W-1:0] : left_q;
		fin_free     = (state_q == ST_FREE) && vld_s1 &&
			(stop_nowrite || (left_eff == CNT_W'(1)) || (addr_s1 == LAST_IDX));
		freed_nx     = freed_q + FC_W'(rel_do && (mem_rd_data != ENT_FREE));
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_IDX) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (acc && go_alloc) begin
					state_nx = ST_SCAN;
				end else if (acc && go_free) begin
					state_nx = ST_FREE;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					state_nx = ST_MARK;
				end else if (scan_fail) begin
					state_nx = ST_IDLE;
				end
			end
			ST_MARK: begin
				if (mark_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_FREE: begin
				if (fin_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		busy        = (state_q != ST_IDLE);
		mem_rd_en   = 1'b0;
		mem_rd_addr = rd_addr_q;
		mem_we      = 1'b0;
		mem_wr_addr = addr_s1;
		mem_wr_data = ENT_FREE;
		case (state_q)
			ST_CLEAR: begin
				mem_we      = 1'b1;
				mem_wr_addr = clr_q;
			end
			ST_SCAN: begin
				mem_rd_en = issue_q;
			end
			ST_MARK: begin
				mem_we      = 1'b1;
				mem_wr_addr = wr_ptr_q;
				mem_wr_data = (wr_ptr_q == start_q) ? ENT_W'(count_q) : CONT_MARK;
			end
			ST_FREE: begin
				mem_rd_en = issue_q;
				mem_we    = rel_do;
			end
			default: begin
				mem_rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			issue_q    <= 1'b0;
			vld_s1     <= 1'b0;
			free_cnt_q <= FC_W'(PAGES);
			res_q      <= '0;
		end else begin
			state_q     <= state_nx;
			res_q.valid <= 1'b0;
			vld_s1      <= issue_q && ((state_q == ST_SCAN) || (state_q == ST_FREE));
			addr_s1     <= rd_addr_q;
			if (issue_q && ((state_q == ST_SCAN) || (state_q == ST_FREE))) begin
				if (rd_addr_q == LAST_IDX) begin
					issue_q <= 1'b0;
				end else begin
					rd_addr_q <= rd_addr_q + IDX_W'(1);
				end
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
				end
				ST_IDLE: begin
					if (acc) begin
						count_q   <= page_count;
						left_q    <= page_count;
						stored_q  <= (op_t'(op) == OP_FREE_RUN);
						first_q   <= 1'b1;
						run_q     <= '0;
						freed_q   <= '0;
						issue_q   <= go_alloc || go_free;
						rd_addr_q <= go_alloc ? '0 : rel[IDX_W-1:0];
						if (!go_alloc && !go_free) begin
							res_q.valid      <= 1'b1;
							res_q.status     <= imm_stat;
							res_q.granted    <= '0;
							res_q.freed      <= '0;
							res_q.free_pages <= sat_cnt(free_cnt_q);
						end
					end
				end
				ST_SCAN: begin
					if (vld_s1) begin
						run_q <= run_nx;
					end
					if (hit) begin
						start_q  <= start_nx;
						wr_ptr_q <= start_nx;
						end_q    <= addr_s1;
						issue_q  <= 1'b0;
					end
					if (scan_fail) begin
						res_q.valid      <= 1'b1;
						res_q.status     <= STAT_NO_ROOM;
						res_q.granted    <= '0;
						res_q.freed      <= '0;
						res_q.free_pages <= sat_cnt(free_cnt_q);
					end
				end
				ST_MARK: begin
					wr_ptr_q <= wr_ptr_q + IDX_W'(1);
					if (mark_last) begin
						free_cnt_q       <= free_cnt_q - FC_W'(count_q);
						res_q.valid      <= 1'b1;
						res_q.status     <= STAT_OK;
						res_q.granted    <= base + PG_W'(start_q);
						res_q.freed      <= '0;
						res_q.free_pages <= sat_cnt(free_cnt_q - FC_W'(count_q));
					end
				end
				ST_FREE: begin
					if (vld_s1) begin
						first_q <= 1'b0;
						left_q  <= left_eff - CNT_W'(1);
						freed_q <= freed_nx;
					end
					if (fin_free) begin
						issue_q          <= 1'b0;
						free_cnt_q       <= free_cnt_q + freed_nx;
						res_q.valid      <= 1'b1;
						res_q.status     <= STAT_OK;
						res_q.granted    <= '0;
						res_q.freed      <= sat_cnt(freed_nx);
						res_q.free_pages <= sat_cnt(free_cnt_q + freed_nx);
					end
				end
				default: begin
					issue_q <= 1'b0;
				end
			endcase
		end
	end

	assign res = res_q;

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mem_we)
		else $error("page map written while idle");

	a_free_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= FC_W'(PAGES))
		else $error("free page count above region size");

	a_rw_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
		else $error("read and write of the same entry in one cycle");

	a_mark_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MARK) |-> (wr_ptr_q <= end_q))
		else $error("run marking passed the end of the run");

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.valid |-> (state_q == ST_IDLE))
		else $error("result strobe while a request is still in progress");

endmodule
